// ===== src/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the multilevel feedback queue tick scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  // item kinds
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_ARRIVAL = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_NUM_LEVELS = 3'd0;
  localparam logic [2:0] REG_QUANTUM0   = 3'd1;
  localparam logic [2:0] REG_QUANTUM3   = 3'd4;

  localparam int NUM_QREGS = 4;

  localparam logic [2:0] NUM_LEVELS_RST = 3'd4;
  localparam logic [NUM_QREGS-1:0][7:0] QUANTUM_RST = {8'd16, 8'd8, 8'd4, 8'd2};

  // widest level and slot index over the supported configurations
  localparam int QLVL_W  = 3;
  localparam int QSLOT_W = 6;

  typedef struct packed {
    logic        func;
    logic [3:0]  proc_slot;
    logic [15:0] burst_length;
  } in_item_t;

  typedef struct packed {
    logic       busy_res;
    logic [3:0] run_slot;
    logic [1:0] run_level;
    logic       finished;
    logic       demoted;
    logic [4:0] live_count;
  } out_item_t;

  // one queue update per cycle: optional pop of a head, optional push at a tail
  typedef struct packed {
    logic               pop;
    logic [QLVL_W-1:0]  pop_lvl;
    logic               push;
    logic [QLVL_W-1:0]  push_lvl;
    logic [QSLOT_W-1:0] push_slot;
  } queue_op_t;

endpackage

// ===== src/mlfq_level_queues.sv =====
// ----------------------------------------------------------------------------
// mlfq_level_queues
// One shifting FIFO of slot numbers per level; the head always sits at entry 0.
// ----------------------------------------------------------------------------
module mlfq_level_queues #(
  parameter int MAX_TASKS  = 16,
  parameter int NUM_LEVELS = 4
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  mlfq_pkg::queue_op_t                         op_i,
  output logic [NUM_LEVELS-1:0][$clog2(MAX_TASKS)-1:0] head_slot_o,
  output logic [NUM_LEVELS-1:0]                       nonempty_o
);

  localparam int SLOT_W = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);

  logic [NUM_LEVELS-1:0][MAX_TASKS-1:0][SLOT_W-1:0] ent_q, ent_d;
  logic [NUM_LEVELS-1:0][CNT_W-1:0]                 cnt_q, cnt_d;

  always_comb begin
    logic             pop_l;
    logic             push_l;
    logic [CNT_W-1:0] wpos;
    ent_d = ent_q;
    cnt_d = cnt_q;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      pop_l  = op_i.pop && (op_i.pop_lvl == mlfq_pkg::QLVL_W'(l)) && (cnt_q[l] != '0);
      push_l = op_i.push && (op_i.push_lvl == mlfq_pkg::QLVL_W'(l)) &&
               (pop_l || (cnt_q[l] != CNT_W'(MAX_TASKS)));
      wpos   = pop_l ? cnt_q[l] - CNT_W'(1) : cnt_q[l];
      for (int i = 0; i < MAX_TASKS; i++) begin
        if (pop_l && (i + 1 < MAX_TASKS)) begin
          ent_d[l][i] = ent_q[l][(i + 1) % MAX_TASKS];
        end
        if (push_l && (wpos == CNT_W'(i))) begin
          ent_d[l][i] = SLOT_W'(op_i.push_slot);
        end
      end
      cnt_d[l] = cnt_q[l] - CNT_W'(pop_l) + CNT_W'(push_l);
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      head_slot_o[l] = ent_q[l][0];
      nonempty_o[l]  = (cnt_q[l] != '0);
    end
  end

endmodule

// ===== src/mlfq_task_table.sv =====
// ----------------------------------------------------------------------------
// mlfq_task_table
// Per-slot remaining burst and remaining quantum, one read and one write port.
// ----------------------------------------------------------------------------
module mlfq_task_table #(
  parameter int MAX_TASKS  = 16,
  parameter int BURST_BITS = 16
) (
  input  logic                          clk_i,
  input  logic [$clog2(MAX_TASKS)-1:0]  rd_slot_i,
  output logic [BURST_BITS-1:0]         rd_burst_o,
  output logic [7:0]                    rd_quant_o,
  input  logic                          wr_en_i,
  input  logic [$clog2(MAX_TASKS)-1:0]  wr_slot_i,
  input  logic [BURST_BITS-1:0]         wr_burst_i,
  input  logic [7:0]                    wr_quant_i
);

  logic [MAX_TASKS-1:0][BURST_BITS-1:0] burst_q;
  logic [MAX_TASKS-1:0][7:0]            quant_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      burst_q[wr_slot_i] <= wr_burst_i;
      quant_q[wr_slot_i] <= wr_quant_i;
    end
  end

  assign rd_burst_o = burst_q[rd_slot_i];
  assign rd_quant_o = quant_q[rd_slot_i];

endmodule

// ===== src/mlfq_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// mlfq_tick_scheduler
// Multilevel feedback queue scheduler, one arrival or one tick per word.
// ----------------------------------------------------------------------------
// Takes one input word per cycle while no tick is held by a stalled output.
// A word sits in the input register, where a priority pick over the level
// heads, a task table lookup and one queue update are done; a tick then
// lands in the result register, from which its result word is offered on
// the output. Arrivals give no result. Sustained rate is one word per cycle
// while no tick is held by a stalled output, set by the single queue update
// and task table write per cycle. Write configuration only while idle.
// ----------------------------------------------------------------------------
module mlfq_tick_scheduler #(
  parameter int MAX_TASKS  = 16,
  parameter int NUM_LEVELS = 4,
  parameter int BURST_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mlfq_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mlfq_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  localparam int SLOT_W = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

  // config
  logic [2:0]                               num_levels_q;
  logic [mlfq_pkg::NUM_QREGS-1:0][7:0]      quant_q;

  // input and result registers
  logic                 in_valid_q;
  mlfq_pkg::in_item_t   in_q;
  logic                 out_valid_q;
  mlfq_pkg::out_item_t  out_q, out_d;

  logic [CNT_W-1:0]     live_q, live_d;

  logic [NUM_LEVELS-1:0][SLOT_W-1:0] head_slot;
  logic [NUM_LEVELS-1:0]             nonempty;
  mlfq_pkg::queue_op_t               qop;

  logic                  is_arrival, proceed, out_free;
  logic                  found, fin, move;
  logic [LVL_W-1:0]      pick, last_lvl, dest;
  logic [SLOT_W-1:0]     cur_slot, arr_slot;
  logic [BURST_BITS-1:0] rd_burst, burst_dec;
  logic [7:0]            rd_quant, quant_dec;
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_slot;
  logic [BURST_BITS-1:0] wr_burst;
  logic [7:0]            wr_quant;

  function automatic logic [SLOT_W-1:0] slot_fold(input logic [3:0] s);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (s == 4'(i)) r = SLOT_W'(i % MAX_TASKS);
    end
    return r;
  endfunction

  // levels past the register file share the last quantum register
  function automatic logic [7:0] quant_of(input logic [LVL_W-1:0] lvl,
                                          input logic [mlfq_pkg::NUM_QREGS-1:0][7:0] q);
    logic [7:0] r;
    r = q[mlfq_pkg::NUM_QREGS-1];
    for (int i = 0; i < mlfq_pkg::NUM_QREGS - 1; i++) begin
      if (int'(lvl) == i) r = q[i];
    end
    return r;
  endfunction

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_levels_q <= mlfq_pkg::NUM_LEVELS_RST;
      quant_q      <= mlfq_pkg::QUANTUM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == mlfq_pkg::REG_NUM_LEVELS) begin
        num_levels_q <= cfg_data_i[2:0];
      end else if (cfg_index_i >= mlfq_pkg::REG_QUANTUM0 &&
                   cfg_index_i <= mlfq_pkg::REG_QUANTUM3) begin
        quant_q[2'(cfg_index_i - mlfq_pkg::REG_QUANTUM0)] <= cfg_data_i;
      end
    end
  end

  // ---------------- handshake ----------------
  assign is_arrival = (in_q.func == mlfq_pkg::FUNC_ARRIVAL);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proceed    = in_valid_q && (is_arrival || out_free);
  assign in_stall_o = in_valid_q && !proceed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      live_q      <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (proceed) begin
        in_valid_q <= 1'b0;
      end
      if (proceed && !is_arrival) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      live_q <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (proceed && !is_arrival) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- pick and update ----------------
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (nonempty[l]) begin
        found = 1'b1;
        pick  = LVL_W'(l);
      end
    end
  end

  always_comb begin
    if (num_levels_q == '0) begin
      last_lvl = '0;
    end else if (int'(num_levels_q) > NUM_LEVELS) begin
      last_lvl = LVL_W'(NUM_LEVELS - 1);
    end else begin
      last_lvl = LVL_W'(num_levels_q - 3'd1);
    end
  end

  assign cur_slot  = head_slot[pick];
  assign arr_slot  = slot_fold(in_q.proc_slot);
  assign burst_dec = rd_burst - BURST_BITS'(1);
  assign quant_dec = (rd_quant == '0) ? '0 : rd_quant - 8'd1;
  // a zero burst at pick time finishes at once
  assign fin       = (rd_burst == '0) || (burst_dec == '0);
  assign move      = !fin && (quant_dec == '0);
  assign dest      = (pick < last_lvl) ? pick + LVL_W'(1) : pick;

  always_comb begin
    wr_en    = 1'b0;
    wr_slot  = cur_slot;
    wr_burst = burst_dec;
    wr_quant = move ? quant_of(dest, quant_q) : quant_dec;
    qop      = '0;
    live_d   = live_q;
    out_d    = '0;
    if (proceed) begin
      if (is_arrival) begin
        if (live_q != CNT_W'(MAX_TASKS)) begin
          wr_en          = 1'b1;
          wr_slot        = arr_slot;
          wr_burst       = BURST_BITS'(in_q.burst_length);
          wr_quant       = quant_of('0, quant_q);
          qop.push       = 1'b1;
          qop.push_lvl   = '0;
          qop.push_slot  = mlfq_pkg::QSLOT_W'(arr_slot);
          live_d         = live_q + CNT_W'(1);
        end
      end else if (found) begin
        wr_en         = (rd_burst != '0);
        qop.pop       = fin || move;
        qop.pop_lvl   = mlfq_pkg::QLVL_W'(pick);
        qop.push      = move;
        qop.push_lvl  = mlfq_pkg::QLVL_W'(dest);
        qop.push_slot = mlfq_pkg::QSLOT_W'(cur_slot);
        if (fin) live_d = live_q - CNT_W'(1);
      end
    end
    out_d.busy_res   = found;
    out_d.run_slot   = found ? 4'(cur_slot) : 4'd0;
    out_d.run_level  = found ? 2'(pick) : 2'd0;
    out_d.finished   = found && fin;
    out_d.demoted    = found && move && (dest != pick);
    out_d.live_count = 5'(live_d);
  end

  mlfq_level_queues #(
    .MAX_TASKS  (MAX_TASKS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_queues (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (qop),
    .head_slot_o (head_slot),
    .nonempty_o  (nonempty)
  );

  mlfq_task_table #(
    .MAX_TASKS  (MAX_TASKS),
    .BURST_BITS (BURST_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rd_slot_i  (cur_slot),
    .rd_burst_o (rd_burst),
    .rd_quant_o (rd_quant),
    .wr_en_i    (wr_en),
    .wr_slot_i  (wr_slot),
    .wr_burst_i (wr_burst),
    .wr_quant_i (wr_quant)
  );

  // ---------------- assertions ----------------
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CNT_W'(MAX_TASKS))
    else $error("live task count above capacity");

  a_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nonempty == '0) == (live_q == '0))
    else $error("queue occupancy disagrees with live count");

  a_arrival_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proceed && is_arrival && live_q != CNT_W'(MAX_TASKS))
      |=> live_q == $past(live_q) + CNT_W'(1))
    else $error("accepted arrival not counted");

  a_idle_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.busy_res) |-> (!out_q.finished && !out_q.demoted))
    else $error("idle tick reports task activity");

  a_fin_demote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.finished && out_q.demoted))
    else $error("task both finished and demoted");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multilevel feedback queue tick scheduler.
// ----------------------------------------------------------------------------
// An in-bench scheduler model predicts one result word per tick. A driver
// feeds arrivals and ticks from a queue, and a monitor checks every result
// word against the oldest prediction. The configuration is rewritten between
// phases while the block is idle, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_PHASES  = 7;
  localparam int PHASE_WORDS = 90;
  localparam int HOLD_CYCLES = 150;
  localparam int SLOTS       = 16;
  localparam int LEVELS      = 4;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  mlfq_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  mlfq_pkg::out_item_t out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i = '0;
  logic [7:0]          cfg_data_i  = '0;

  mlfq_tick_scheduler dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // scheduler model state
  logic [3:0]  level_slots [LEVELS][SLOTS];
  int unsigned level_head [LEVELS];
  int unsigned level_count [LEVELS];
  logic [15:0] slot_burst [SLOTS];
  logic [7:0]  slot_quantum [SLOTS];
  int unsigned live_tasks;
  logic [2:0]  cfg_levels;
  logic [7:0]  cfg_quantum [mlfq_pkg::NUM_QREGS];

  mlfq_pkg::in_item_t  pending_words [$];
  mlfq_pkg::out_item_t expected_results [$];

  int unsigned error_count, words_sent, results_seen;
  int unsigned idle_ticks, finishes, demotions, ignored_arrivals, reg_writes;
  bit calm, hold_armed, hold_done;

  function automatic void enqueue_slot(int lvl, logic [3:0] slot);
    level_slots[lvl][(level_head[lvl] + level_count[lvl]) % SLOTS] = slot;
    level_count[lvl]++;
  endfunction

  function automatic logic [7:0] quantum_of(int lvl);
    return cfg_quantum[(lvl < mlfq_pkg::NUM_QREGS) ? lvl : mlfq_pkg::NUM_QREGS - 1];
  endfunction

  // advance the model by one accepted word, queue the tick's result
  function automatic void schedule_word(mlfq_pkg::in_item_t w);
    mlfq_pkg::out_item_t r;
    int                  lvl, last_lvl, dest;
    logic [3:0]          slot;
    logic                done, moved;
    r = '0;
    if (w.func == mlfq_pkg::FUNC_ARRIVAL) begin
      if (live_tasks >= SLOTS) begin
        ignored_arrivals++;
      end else begin
        slot_burst[w.proc_slot]   = w.burst_length;
        slot_quantum[w.proc_slot] = quantum_of(0);
        enqueue_slot(0, w.proc_slot);
        live_tasks++;
      end
      return;
    end
    lvl = 0;
    while (lvl < LEVELS && level_count[lvl] == 0) lvl++;
    if (lvl == LEVELS) begin
      r.live_count = live_tasks[4:0];
      idle_ticks++;
      expected_results.push_back(r);
      return;
    end
    slot  = level_slots[lvl][level_head[lvl]];
    done  = 1'b0;
    moved = 1'b0;
    if (slot_burst[slot] == 16'd0) begin
      done = 1'b1;
    end else begin
      slot_burst[slot]--;
      if (slot_quantum[slot] != 8'd0) slot_quantum[slot]--;
      done = (slot_burst[slot] == 16'd0);
    end
    if (done || slot_quantum[slot] == 8'd0) begin
      level_head[lvl] = (level_head[lvl] + 1) % SLOTS;
      level_count[lvl]--;
    end
    if (done) begin
      live_tasks--;
      finishes++;
    end else if (slot_quantum[slot] == 8'd0) begin
      // the last level in use and any past it keep their tasks round robin
      last_lvl = (cfg_levels == 3'd0) ? 0 : (cfg_levels > LEVELS) ? LEVELS - 1 : cfg_levels - 1;
      dest  = (lvl < last_lvl) ? lvl + 1 : lvl;
      moved = (dest != lvl);
      slot_quantum[slot] = quantum_of(dest);
      enqueue_slot(dest, slot);
      if (moved) demotions++;
    end
    r.busy_res   = 1'b1;
    r.run_slot   = slot;
    r.run_level  = lvl[1:0];
    r.finished   = done;
    r.demoted    = moved;
    r.live_count = live_tasks[4:0];
    expected_results.push_back(r);
  endfunction

  function automatic mlfq_pkg::in_item_t tick_word();
    mlfq_pkg::in_item_t w;
    w = '0;
    w.func         = mlfq_pkg::FUNC_TICK;
    w.proc_slot    = 4'($urandom);
    w.burst_length = 16'($urandom);
    return w;
  endfunction

  function automatic mlfq_pkg::in_item_t arrival_word(logic [3:0] slot, logic [15:0] burst);
    mlfq_pkg::in_item_t w;
    w.func         = mlfq_pkg::FUNC_ARRIVAL;
    w.proc_slot    = slot;
    w.burst_length = burst;
    return w;
  endfunction

  function automatic mlfq_pkg::in_item_t random_word(int arrival_pct);
    int unsigned pick;
    logic [15:0] burst;
    if ($urandom_range(0, 99) >= arrival_pct) return tick_word();
    pick = $urandom_range(0, 99);
    if (pick < 2) burst = 16'($urandom);
    else if (pick < 4) burst = 16'd0;
    else burst = 16'($urandom_range(1, 12));
    return arrival_word(4'($urandom), burst);
  endfunction

  // driver: one word per handshake, random gaps between words
  int unsigned send_gap;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        schedule_word(in_data_i);
        words_sent++;
      end
      if (in_valid_i && in_stall_o) begin
        // stalled word stays put
      end else if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (!calm && $urandom_range(0, 99) < 8) begin
        in_valid_i <= 1'b0;
        send_gap   <= $urandom_range(0, 7);
      end else if (pending_words.size() != 0) begin
        in_data_i  <= pending_words.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: check each result word, random stalls plus one long hold-off
  int unsigned stall_left, hold_count;
  always @(posedge clk_i) begin
    mlfq_pkg::out_item_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      hold_count  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: %p", out_data_o);
          error_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_data_o.busy_res !== e.busy_res) begin
            $error("busy_res: expected %0d, got %0d", e.busy_res, out_data_o.busy_res);
            error_count++;
          end
          if (out_data_o.run_slot !== e.run_slot) begin
            $error("run_slot: expected %0d, got %0d", e.run_slot, out_data_o.run_slot);
            error_count++;
          end
          if (out_data_o.run_level !== e.run_level) begin
            $error("run_level: expected %0d, got %0d", e.run_level, out_data_o.run_level);
            error_count++;
          end
          if (out_data_o.finished !== e.finished) begin
            $error("finished: expected %0d, got %0d", e.finished, out_data_o.finished);
            error_count++;
          end
          if (out_data_o.demoted !== e.demoted) begin
            $error("demoted: expected %0d, got %0d", e.demoted, out_data_o.demoted);
            error_count++;
          end
          if (out_data_o.live_count !== e.live_count) begin
            $error("live_count: expected %0d, got %0d", e.live_count, out_data_o.live_count);
            error_count++;
          end
        end
      end
      if (hold_armed && !hold_done) begin
        out_stall_i <= 1'b1;
        hold_count  <= hold_count + 1;
        if (hold_count == HOLD_CYCLES) hold_done <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < 8) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 7);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // call at a clock edge; returns at the edge where the write is taken
  task automatic write_register(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == mlfq_pkg::REG_NUM_LEVELS) cfg_levels = val[2:0];
    else cfg_quantum[idx - mlfq_pkg::REG_QUANTUM0] = val;
    reg_writes++;
  endtask

  // wait until all words are in and all results are out, then let the pipe settle
  task automatic wait_quiet(input int settle);
    do @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // per phase: num_levels, quantum 0..3
  logic [7:0] phase_cfg [NUM_PHASES][5] = '{
    '{8'd4, 8'd1,   8'd1,   8'd1,   8'd1},
    '{8'd1, 8'd255, 8'd255, 8'd255, 8'd255},
    '{8'd0, 8'd0,   8'd3,   8'd0,   8'd5},
    '{8'd7, 8'd2,   8'd3,   8'd4,   8'd5},
    '{8'd2, 8'd3,   8'd5,   8'd7,   8'd9},
    '{8'd3, 8'd1,   8'd2,   8'd3,   8'd4},
    '{8'd4, 8'd2,   8'd4,   8'd8,   8'd16}
  };
  int phase_arrival_pct [NUM_PHASES] = '{35, 30, 40, 60, 15, 35, 30};

  initial begin
    live_tasks = 0;
    cfg_levels = mlfq_pkg::NUM_LEVELS_RST;
    for (int i = 0; i < LEVELS; i++) begin
      level_head[i]  = 0;
      level_count[i] = 0;
    end
    for (int i = 0; i < mlfq_pkg::NUM_QREGS; i++) cfg_quantum[i] = mlfq_pkg::QUANTUM_RST[i];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle tick, one-tick task, all-ones and zero bursts,
    // demotion, preemption of a lower level, slot reuse
    pending_words.push_back(tick_word());
    pending_words.push_back(arrival_word(4'd0, 16'd1));
    pending_words.push_back(tick_word());
    pending_words.push_back(arrival_word(4'd15, 16'hFFFF));
    pending_words.push_back(arrival_word(4'd5, 16'd0));
    pending_words.push_back(arrival_word(4'd10, 16'd3));
    repeat (5) pending_words.push_back(tick_word());
    pending_words.push_back(arrival_word(4'd10, 16'd2));
    pending_words.push_back(arrival_word(4'd3, 16'd6));
    pending_words.push_back(arrival_word(4'd10, 16'd1));
    repeat (8) pending_words.push_back(tick_word());
    wait_quiet(4);

    for (int p = 0; p < NUM_PHASES; p++) begin
      calm = (p == NUM_PHASES - 1);
      write_register(mlfq_pkg::REG_NUM_LEVELS, phase_cfg[p][0]);
      for (int q = 0; q < mlfq_pkg::NUM_QREGS; q++)
        write_register(mlfq_pkg::REG_QUANTUM0 + 3'(q), phase_cfg[p][q + 1]);
      cfg_valid_i <= 1'b0;
      // the receiver holds off while this phase's words pile up
      if (p == 2) hold_armed = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++)
        pending_words.push_back(random_word(phase_arrival_pct[p]));
      wait_quiet(4);
    end

    wait_quiet(10);
    $display("Sent %0d words over %0d phases, %0d register writes; checked %0d results",
             words_sent, NUM_PHASES + 1, reg_writes, results_seen);
    $display("  idle ticks %0d, finishes %0d, demotions %0d, arrivals dropped when full %0d",
             idle_ticks, finishes, demotions, ignored_arrivals);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("timeout: %0d words pending, %0d results outstanding",
             pending_words.size(), expected_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/mlfq_pkg.sv
src/mlfq_level_queues.sv
src/mlfq_task_table.sv
src/mlfq_tick_scheduler.sv
tb/sv/tb.sv
